### sv/ccs_pkg.sv
// Shared types and character codes of the comment stripper.
`default_nettype none
package ccs_pkg;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Scanner state carried from one byte to the next
  typedef struct packed {
    logic in_line;
    logic in_block;
    logic prev_slash;
    logic prev_star;
    logic slash_held;
  } state_t;

  // Results caused by one byte: an optional released slash, then the byte
  typedef struct packed {
    logic       rel_slash;
    logic       emit;
    logic [7:0] data;
  } res_t;

endpackage
`default_nettype wire

### sv/ccs_step.sv
// Next-state and result logic for one byte of the comment stripper.
`default_nettype none
module ccs_step (
  input  logic [7:0]      in_byte_i,
  input  logic            text_start_i,
  input  ccs_pkg::state_t state_i,
  output ccs_pkg::state_t state_o,
  output ccs_pkg::res_t   res_o
);

  logic            is_slash;
  logic            is_star;
  logic            is_nl;
  ccs_pkg::state_t cur;
  ccs_pkg::state_t nxt;
  ccs_pkg::res_t   res;

  assign is_slash = (in_byte_i == ccs_pkg::CH_SLASH);
  assign is_star  = (in_byte_i == ccs_pkg::CH_STAR);
  assign is_nl    = (in_byte_i == ccs_pkg::CH_NEWLINE);

  // Clear the state at the first byte of a new text
  assign cur = text_start_i ? '0 : state_i;

  always_comb begin
    nxt = cur;
    res = '0;
    res.data = in_byte_i;

    // Open comments, end a line comment
    if (is_slash) begin
      if (cur.prev_slash) begin
        nxt.in_line    = 1'b1;
        nxt.slash_held = 1'b0;
      end
    end else if (is_star) begin
      if (cur.prev_slash) begin
        nxt.in_block   = 1'b1;
        nxt.slash_held = 1'b0;
      end
    end else if (is_nl) begin
      nxt.in_line = 1'b0;
    end

    // Hold a slash, or pass the byte and release any held slash ahead of it
    if (!nxt.in_line && !nxt.in_block) begin
      if (is_slash) begin
        nxt.slash_held = 1'b1;
      end else begin
        res.rel_slash  = nxt.slash_held;
        res.emit       = 1'b1;
        nxt.slash_held = 1'b0;
      end
    end

    // Close a block comment; the closing slash still counts as a slash
    if (is_slash && cur.prev_star) begin
      nxt.in_block = 1'b0;
    end

    nxt.prev_slash = is_slash;
    nxt.prev_star  = is_star;
  end

  assign state_o = nxt;
  assign res_o   = res;

endmodule
`default_nettype wire

### sv/ccs_out.sv
// Result register of the comment stripper: sends a released slash, then the byte.
`default_nettype none
module ccs_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  ccs_pkg::res_t res_i,
  output logic          free_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,
  output logic          m_axis_tlast
);

  logic       slash_q, slash_d;
  logic       byte_q, byte_d;
  logic [7:0] data_q;
  logic       pop;

  assign m_axis_tvalid = slash_q | byte_q;
  assign m_axis_tdata  = slash_q ? ccs_pkg::CH_SLASH : data_q;
  assign m_axis_tlast  = !slash_q;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // Free once empty or when the last pending transaction goes out now
  assign free_o = !m_axis_tvalid || (pop && !slash_q);

  // Drop the sent transaction, then load the next results
  always_comb begin
    slash_d = slash_q;
    byte_d  = byte_q;
    if (pop) begin
      if (slash_q) begin
        slash_d = 1'b0;
      end else begin
        byte_d = 1'b0;
      end
    end
    if (load_i) begin
      slash_d = res_i.rel_slash;
      byte_d  = res_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slash_q <= 1'b0;
      byte_q  <= 1'b0;
    end else begin
      slash_q <= slash_d;
      byte_q  <= byte_d;
    end
  end

  // Hold the byte payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i.data;
    end
  end

endmodule
`default_nettype wire

### sv/c_comment_stripper.sv
// Top level of the C comment stripper: input register, scanner state, result register.
//
//  channel   dir  tdata          tuser        tlast
//  s_axis    in   in_byte[7:0]   text_start   -
//  m_axis    out  out_byte[7:0]  -            run_last
//
// One byte per cycle unless the output stalls or a slash is released: a byte moves
// from the input register through the scanner into the result register when free.
// A byte releasing a held slash gives two output transactions and holds the result register until both go.
// Reset clears the scanner state and all valid flags; no clearing pass.
// With the output stalled, the input register takes one more byte, then
// s_axis_tready falls.
`default_nettype none
module c_comment_stripper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] text_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic            in_vld_q, in_vld_d;
  logic [7:0]      in_byte_q;
  logic            in_start_q;
  ccs_pkg::state_t state_q;
  ccs_pkg::state_t state_nxt;
  ccs_pkg::res_t   res;
  logic            res_free;
  logic            advance;
  logic            accept;

  assign advance       = in_vld_q && res_free;
  assign s_axis_tready = !in_vld_q || res_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input register valid
  always_comb begin
    in_vld_d = in_vld_q;
    if (advance) begin
      in_vld_d = 1'b0;
    end
    if (accept) begin
      in_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      state_q  <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (advance) begin
        state_q <= state_nxt;
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  ccs_step u_step (
    .in_byte_i    (in_byte_q),
    .text_start_i (in_start_q),
    .state_i      (state_q),
    .state_o      (state_nxt),
    .res_o        (res)
  );

  ccs_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance),
    .res_i         (res),
    .free_o        (res_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

### sv/ccs_checker.sv
// Port-level checks of the comment stripper and their bind to the top level.
`default_nettype none
module ccs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // A leading transaction of a pair is always a released slash
  a_lead_is_slash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata == ccs_pkg::CH_SLASH))
    else $error("leading transaction is not a slash");

  // A slash is never passed as the byte itself
  a_no_last_slash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata != ccs_pkg::CH_SLASH))
    else $error("slash sent as the current byte");

  // The byte follows its released slash at once
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("released slash not followed by its byte");

  // A stalled transaction holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output transaction changed");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
